// ----- hdl/refcounted_page_frame_allocator_top_macros.svh -----
// Assertion macros for the page frame allocator top level.
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rpfa_pkg.sv -----
// Types and codes of the page frame allocator.
package rpfa_pkg;

    localparam int ADDR_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int REF_OUT_W   = 8;
    localparam int FREE_OUT_W  = 15;

    localparam logic [ADDR_W-1:0] MEMORY_TOP_RESET = 32'd234881024;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_ADDREF  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD     = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOWEST = 1'b0,
        CFG_TOP    = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_STACK = 5'b00100,
        S_COUNT = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

endpackage

// ----- hdl/rpfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/refcounted_page_frame_allocator_top.sv -----
// Top level of the reference counted page frame allocator.
// Usage: requests enter on in_valid/in_ready with mode and page_address;
//   each yields one result on out_valid/out_ready (status, frame_address,
//   ref_count, free_frames, returned_to_pool). Allocate pops the LIFO free
//   stack and counts the frame up; release checks the address, counts down
//   and pushes the frame at count zero; add-reference counts up.
//   cfg_we/cfg_index/cfg_data write lowest_address and memory_top while idle.
// Sequence after acceptance: allocate from a non-empty stack reads the stack
//   RAM at acceptance, then passes S_STACK (count read), S_COUNT (count write)
//   and S_OUT (result load); release / add-reference with a good address pass
//   S_COUNT and S_OUT; any other request goes straight to S_OUT. The next
//   request is accepted in the cycle after the result load, so a request is
//   not accepted before the last one is through.
// Reset: rst_n clears control state, then a clearing pass writes zero to
//   every count entry with in_ready low. The free stack RAM is not cleared;
//   only entries below the stack depth are ever read.
// Stall: a result waits in the output register; one more request may be
//   accepted and finished meanwhile, then in_ready stays low until it frees.
module refcounted_page_frame_allocator_top #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_FRAMES = 16384,
    parameter int COUNT_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [rpfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rpfa_pkg::ADDR_W-1:0]          cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [rpfa_pkg::ADDR_W-1:0]          page_address,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic [rpfa_pkg::ADDR_W-1:0]          frame_address,
    output logic [rpfa_pkg::REF_OUT_W-1:0]       ref_count,
    output logic [rpfa_pkg::FREE_OUT_W-1:0]      free_frames,
    output logic                                 returned_to_pool
);

`include "refcounted_page_frame_allocator_top_macros.svh"

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int DEPTH_W    = $clog2(MAX_FRAMES + 1);
    localparam int CNT_EXT_W  = (COUNT_BITS > rpfa_pkg::REF_OUT_W) ?
                                COUNT_BITS : rpfa_pkg::REF_OUT_W;
    localparam int DEP_EXT_W  = (DEPTH_W > rpfa_pkg::FREE_OUT_W) ?
                                DEPTH_W : rpfa_pkg::FREE_OUT_W;
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(MAX_FRAMES - 1);
    localparam logic [DEPTH_W-1:0]    FULL_DEP  = DEPTH_W'(MAX_FRAMES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // control registers
    rpfa_pkg::state_t                 state_reg, state_next;
    logic [DEPTH_W-1:0]               depth_reg, depth_next;
    logic [IDX_W-1:0]                 clr_reg, clr_next;
    logic [rpfa_pkg::ADDR_W-1:0]      lowest_reg, lowest_next;
    logic [rpfa_pkg::ADDR_W-1:0]      top_reg, top_next;
    logic                             out_valid_reg, out_valid_next;

    // request and pending result (payload, no reset)
    rpfa_pkg::mode_t                  mode_reg, mode_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    rpfa_pkg::status_t                p_status_reg, p_status_next;
    logic [rpfa_pkg::ADDR_W-1:0]      p_frame_reg, p_frame_next;
    logic [COUNT_BITS-1:0]            p_count_reg, p_count_next;
    logic                             p_push_reg, p_push_next;

    // output register (payload)
    rpfa_pkg::status_t                o_status_reg, o_status_next;
    logic [rpfa_pkg::ADDR_W-1:0]      o_frame_reg, o_frame_next;
    logic [COUNT_BITS-1:0]            o_count_reg, o_count_next;
    logic [DEPTH_W-1:0]               o_depth_reg, o_depth_next;
    logic                             o_push_reg, o_push_next;

    // RAM ports
    logic                             cnt_we;
    logic [IDX_W-1:0]                 cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]            cnt_wdata, cnt_rdata;
    logic                             stk_we;
    logic [IDX_W-1:0]                 stk_waddr, stk_raddr, stk_rdata;

    // address check on the incoming request
    rpfa_pkg::mode_t                  in_mode;
    logic [rpfa_pkg::ADDR_W-1:0]      in_page;
    logic [IDX_W-1:0]                 in_idx;
    logic                             in_ok;
    logic                             accept;
    logic                             out_free;
    logic [DEPTH_W-1:0]               depth_dec;
    logic [COUNT_BITS-1:0]            cnt_new;
    logic [CNT_EXT_W-1:0]             cnt_ext;
    logic [DEP_EXT_W-1:0]             dep_ext;

    assign in_mode   = rpfa_pkg::mode_t'(mode);
    assign in_page   = page_address >> PAGE_SHIFT;
    assign in_idx    = in_page[IDX_W-1:0];
    assign in_ok     = (page_address[PAGE_SHIFT-1:0] == '0) &&
                       (page_address >= lowest_reg) &&
                       (page_address < top_reg) &&
                       (in_page < rpfa_pkg::ADDR_W'(MAX_FRAMES));
    assign in_ready  = (state_reg == rpfa_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign depth_dec = depth_reg - 1'b1;

    // saturating count update on the value just read
    always_comb
    begin
        if (mode_reg == rpfa_pkg::MODE_RELEASE)
        begin
            cnt_new = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;
        end
        else
        begin
            cnt_new = (cnt_rdata != COUNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
        end
    end

    // stack is read at top-of-stack in idle, written at depth on a push
    assign stk_raddr = depth_dec[IDX_W-1:0];
    assign stk_waddr = depth_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        clr_next       = clr_reg;
        lowest_next    = lowest_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        p_status_next  = p_status_reg;
        p_frame_next   = p_frame_reg;
        p_count_next   = p_count_reg;
        p_push_next    = p_push_reg;
        o_status_next  = o_status_reg;
        o_frame_next   = o_frame_reg;
        o_count_next   = o_count_reg;
        o_depth_next   = o_depth_reg;
        o_push_next    = o_push_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = idx_reg;
        cnt_wdata      = cnt_new;
        cnt_raddr      = in_idx;
        stk_we         = 1'b0;

        if (cfg_we)
        begin
            case (rpfa_pkg::cfg_index_t'(cfg_index))
                rpfa_pkg::CFG_LOWEST: lowest_next = cfg_data;
                rpfa_pkg::CFG_TOP:    top_next    = cfg_data;
                default:              lowest_next = lowest_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rpfa_pkg::S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = rpfa_pkg::S_IDLE;
                end
            end
            rpfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = in_mode;
                    idx_next      = in_idx;
                    p_status_next = rpfa_pkg::ST_OK;
                    p_frame_next  = '0;
                    p_count_next  = '0;
                    p_push_next   = 1'b0;
                    state_next    = rpfa_pkg::S_OUT;
                    case (in_mode)
                        rpfa_pkg::MODE_ALLOC:
                        begin
                            if (depth_reg == '0)
                            begin
                                p_status_next = rpfa_pkg::ST_NO_FREE;
                            end
                            else
                            begin
                                depth_next = depth_dec;
                                state_next = rpfa_pkg::S_STACK;
                            end
                        end
                        rpfa_pkg::MODE_RELEASE,
                        rpfa_pkg::MODE_ADDREF:
                        begin
                            if (in_ok)
                            begin
                                state_next = rpfa_pkg::S_COUNT;
                            end
                            else
                            begin
                                p_status_next = rpfa_pkg::ST_BAD;
                            end
                        end
                        default:
                        begin
                            p_status_next = rpfa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            rpfa_pkg::S_STACK:
            begin
                // popped frame index arrives; fetch its count
                idx_next   = stk_rdata;
                cnt_raddr  = stk_rdata;
                state_next = rpfa_pkg::S_COUNT;
            end
            rpfa_pkg::S_COUNT:
            begin
                cnt_we       = 1'b1;
                p_count_next = cnt_new;
                state_next   = rpfa_pkg::S_OUT;
                if (mode_reg == rpfa_pkg::MODE_ALLOC)
                begin
                    p_frame_next = rpfa_pkg::ADDR_W'(idx_reg) << PAGE_SHIFT;
                end
                if ((mode_reg == rpfa_pkg::MODE_RELEASE) && (cnt_new == '0))
                begin
                    if (depth_reg == FULL_DEP)
                    begin
                        p_status_next = rpfa_pkg::ST_FULL;
                    end
                    else
                    begin
                        stk_we      = 1'b1;
                        depth_next  = depth_reg + 1'b1;
                        p_push_next = 1'b1;
                    end
                end
            end
            rpfa_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    o_status_next  = p_status_reg;
                    o_frame_next   = p_frame_reg;
                    o_count_next   = p_count_reg;
                    o_depth_next   = depth_reg;
                    o_push_next    = p_push_reg;
                    out_valid_next = 1'b1;
                    state_next     = rpfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpfa_pkg::S_CLEAR;
            depth_reg     <= '0;
            clr_reg       <= '0;
            lowest_reg    <= '0;
            top_reg       <= rpfa_pkg::MEMORY_TOP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            clr_reg       <= clr_next;
            lowest_reg    <= lowest_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        idx_reg      <= idx_next;
        p_status_reg <= p_status_next;
        p_frame_reg  <= p_frame_next;
        p_count_reg  <= p_count_next;
        p_push_reg   <= p_push_next;
        o_status_reg <= o_status_next;
        o_frame_reg  <= o_frame_next;
        o_count_reg  <= o_count_next;
        o_depth_reg  <= o_depth_next;
        o_push_reg   <= o_push_next;
    end

    // reference counts, one per frame
    rpfa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // LIFO of free frame indices
    rpfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_FRAMES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (idx_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign cnt_ext          = CNT_EXT_W'(o_count_reg);
    assign dep_ext          = DEP_EXT_W'(o_depth_reg);
    assign out_valid        = out_valid_reg;
    assign status           = o_status_reg;
    assign frame_address    = o_frame_reg;
    assign ref_count        = cnt_ext[rpfa_pkg::REF_OUT_W-1:0];
    assign free_frames      = dep_ext[rpfa_pkg::FREE_OUT_W-1:0];
    assign returned_to_pool = o_push_reg;

    `RPFA_ASSERT_NOW(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= FULL_DEP,
        "stack depth above frame count")
    `RPFA_ASSERT_NOW(a_push_room, clk, rst_n, stk_we, depth_reg < FULL_DEP,
        "push onto a full stack")
    `RPFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, !in_ready,
        "request accepted while another is in flight")
    `RPFA_ASSERT_NOW(a_push_ok, clk, rst_n, out_valid_reg && o_push_reg,
        o_status_reg == rpfa_pkg::ST_OK, "frame pushed with a failing status")

endmodule

// ----- tb/sv/rpfa_frame_checker.sv -----
// Checker for the page frame allocator: tracks frame state and compares every result.
`timescale 1ns / 1ps

module rpfa_frame_checker #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_FRAMES = 16384,
    parameter int COUNT_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rpfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rpfa_pkg::ADDR_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [rpfa_pkg::ADDR_W-1:0]          page_address,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [1:0]                           status,
    input  logic [rpfa_pkg::ADDR_W-1:0]          frame_address,
    input  logic [rpfa_pkg::REF_OUT_W-1:0]       ref_count,
    input  logic [rpfa_pkg::FREE_OUT_W-1:0]      free_frames,
    input  logic                                 returned_to_pool,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        rpfa_pkg::status_t                status;
        logic [rpfa_pkg::ADDR_W-1:0]      frame_address;
        logic [rpfa_pkg::REF_OUT_W-1:0]   ref_count;
        logic [rpfa_pkg::FREE_OUT_W-1:0]  free_frames;
        logic                             returned_to_pool;
    } frame_result_t;

    logic [FRAME_W-1:0]          pool_stack [MAX_FRAMES];
    logic [COUNT_BITS-1:0]       frame_refs [MAX_FRAMES];
    int                          pool_depth;
    logic [rpfa_pkg::ADDR_W-1:0] win_lo;
    logic [rpfa_pkg::ADDR_W-1:0] win_top;
    frame_result_t               owed_results [$];
    frame_result_t               oldest;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // window check shared by release and add-reference
    function automatic logic frame_in_window(input logic [rpfa_pkg::ADDR_W-1:0] addr);
        return (addr % PAGE_BYTES) == 0 && addr >= win_lo && addr < win_top &&
               (addr / PAGE_BYTES) < MAX_FRAMES;
    endfunction

    function automatic frame_result_t apply_frame_op(
        input rpfa_pkg::mode_t op, input logic [rpfa_pkg::ADDR_W-1:0] addr);
        frame_result_t r;
        int unsigned   idx;
        logic          ok;
        r      = '0;
        ok     = frame_in_window(addr);
        idx    = addr / PAGE_BYTES;
        case (op)
            rpfa_pkg::MODE_ALLOC:
            begin
                if (pool_depth == 0)
                    r.status = rpfa_pkg::ST_NO_FREE;
                else
                begin
                    pool_depth--;
                    idx = pool_stack[pool_depth];
                    if (frame_refs[idx] != COUNT_MAX)
                        frame_refs[idx]++;
                    r.ref_count     = rpfa_pkg::REF_OUT_W'(frame_refs[idx]);
                    r.frame_address = rpfa_pkg::ADDR_W'(idx * PAGE_BYTES);
                end
            end
            rpfa_pkg::MODE_RELEASE:
            begin
                if (!ok)
                    r.status = rpfa_pkg::ST_BAD;
                else
                begin
                    if (frame_refs[idx] != 0)
                        frame_refs[idx]--;
                    r.ref_count = rpfa_pkg::REF_OUT_W'(frame_refs[idx]);
                    if (frame_refs[idx] == 0)
                    begin
                        if (pool_depth >= MAX_FRAMES)
                            r.status = rpfa_pkg::ST_FULL;
                        else
                        begin
                            pool_stack[pool_depth] = FRAME_W'(idx);
                            pool_depth++;
                            r.returned_to_pool = 1'b1;
                        end
                    end
                end
            end
            rpfa_pkg::MODE_ADDREF:
            begin
                if (!ok)
                    r.status = rpfa_pkg::ST_BAD;
                else
                begin
                    if (frame_refs[idx] != COUNT_MAX)
                        frame_refs[idx]++;
                    r.ref_count = rpfa_pkg::REF_OUT_W'(frame_refs[idx]);
                end
            end
            default: ;
        endcase
        r.free_frames = rpfa_pkg::FREE_OUT_W'(pool_depth);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
                frame_refs[i] = '0;
            pool_depth = 0;
            win_lo     = '0;
            win_top    = rpfa_pkg::MEMORY_TOP_RESET;
            owed_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (rpfa_pkg::cfg_index_t'(cfg_index))
                    rpfa_pkg::CFG_LOWEST: win_lo  = cfg_data;
                    rpfa_pkg::CFG_TOP:    win_top = cfg_data;
                    default: ;
                endcase
            end
            // a result always belongs to a request accepted at an earlier edge
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("result with no request waiting", 32'(status), 0);
                else
                begin
                    oldest = owed_results.pop_front();
                    check_field("status", 32'(status), 32'(oldest.status));
                    check_field("frame_address", frame_address, oldest.frame_address);
                    check_field("ref_count", 32'(ref_count), 32'(oldest.ref_count));
                    check_field("free_frames", 32'(free_frames), 32'(oldest.free_frames));
                    check_field("returned_to_pool", 32'(returned_to_pool),
                                32'(oldest.returned_to_pool));
                end
            end
            if (in_valid && in_ready)
                owed_results.push_back(apply_frame_op(rpfa_pkg::mode_t'(mode),
                                                      page_address));
            outstanding = owed_results.size();
        end
    end

endmodule

// ----- tb/sv/refcounted_page_frame_allocator_top_tb.sv -----
// Testbench top for the page frame allocator: request stimulus, result sink and verdict.
`timescale 1ns / 1ps

module refcounted_page_frame_allocator_top_tb;

    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_FRAMES    = 16384;
    localparam int COUNT_BITS    = 8;
    localparam logic [31:0] PAGE_MASK = PAGE_BYTES - 1;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 76;
    localparam int HOLD_CYCLES   = 400;
    // the clearing pass after reset and the long result hold-off both stay
    // inside this limit with several times the margin
    localparam int STALL_LIMIT   = 100000;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [rpfa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rpfa_pkg::ADDR_W-1:0]      cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [1:0]                       mode;
    logic [rpfa_pkg::ADDR_W-1:0]      page_address;
    logic                             out_valid;
    logic                             out_ready;
    logic [1:0]                       status;
    logic [rpfa_pkg::ADDR_W-1:0]      frame_address;
    logic [rpfa_pkg::REF_OUT_W-1:0]   ref_count;
    logic [rpfa_pkg::FREE_OUT_W-1:0]  free_frames;
    logic                             returned_to_pool;

    int                     mismatches;
    int                     outstanding;

    // idle knobs per side, and the one-shot long hold-off on the result side
    bit                     tx_idle;
    bit                     rx_idle;
    bit                     hold_off;

    // the window as last written, used to aim request addresses
    logic [31:0]            window_lo;
    logic [31:0]            window_top;

    refcounted_page_frame_allocator_top #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_FRAMES (MAX_FRAMES),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .page_address     (page_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .frame_address    (frame_address),
        .ref_count        (ref_count),
        .free_frames      (free_frames),
        .returned_to_pool (returned_to_pool)
    );

    rpfa_frame_checker #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_FRAMES (MAX_FRAMES),
        .COUNT_BITS (COUNT_BITS)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .page_address     (page_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .frame_address    (frame_address),
        .ref_count        (ref_count),
        .free_frames      (free_frames),
        .returned_to_pool (returned_to_pool),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One request: optional gap with valid low, then valid held with a steady
    // payload until the accepting edge. Valid stays high on return so that a
    // back-to-back request does not drop it.
    task automatic send_request(input rpfa_pkg::mode_t op, input logic [31:0] addr);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= op;
        page_address <= addr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Window registers change only with nothing in flight and the block ready
    // (which also covers the clearing pass after reset).
    task automatic set_window(input logic [31:0] lo, input logic [31:0] top);
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0 || !in_ready)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rpfa_pkg::CFG_LOWEST;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= rpfa_pkg::CFG_TOP;
        cfg_data  <= top;
        @(negedge clk);
        cfg_we     <= 1'b0;
        window_lo  = lo;
        window_top = top;
    endtask

    // A frame address from the bottom of the current window (frames 0..15 if it holds
    // none), from at most 16 frames so allocates, releases and extra references collide.
    function automatic logic [31:0] window_frame();
        longint first;
        longint last;
        longint span;
        first = (longint'(window_lo) + PAGE_BYTES - 1) / PAGE_BYTES;
        if (window_top == 0)
            last = -1;
        else
            last = (longint'(window_top) - 1) / PAGE_BYTES;
        if (last > MAX_FRAMES - 1)
            last = MAX_FRAMES - 1;
        if (first > last)
            return 32'($urandom_range(0, 15) * PAGE_BYTES);
        span = last - first + 1;
        if (span > 16)
            span = 16;
        return 32'((first + $urandom_range(0, span - 1)) * PAGE_BYTES);
    endfunction

    // Mostly well formed traffic on the pool, with a share of ignored modes and
    // addresses that break alignment, either window edge or the frame range.
    task automatic random_request();
        int unsigned     pick;
        rpfa_pkg::mode_t op;
        logic [31:0]     addr;
        pick = $urandom_range(0, 99);
        addr = $urandom;
        if (pick < 30)
            op = rpfa_pkg::MODE_ALLOC;
        else if (pick < 60)
        begin
            op   = rpfa_pkg::MODE_RELEASE;
            addr = window_frame();
        end
        else if (pick < 80)
        begin
            op   = rpfa_pkg::MODE_ADDREF;
            addr = window_frame();
        end
        else if (pick < 85)
            op = rpfa_pkg::MODE_NONE;
        else
        begin
            if ($urandom_range(0, 1) != 0)
                op = rpfa_pkg::MODE_RELEASE;
            else
                op = rpfa_pkg::MODE_ADDREF;
            case ($urandom_range(0, 5))
                0: addr = window_frame() | 32'($urandom_range(1, PAGE_BYTES - 1));
                1: ;
                2: addr = (window_lo - 1) & ~PAGE_MASK;
                3: addr = window_top;
                4: addr = (window_top + PAGE_MASK) & ~PAGE_MASK;
                default: addr = 32'(MAX_FRAMES * PAGE_BYTES) +
                                32'($urandom_range(0, 255) * PAGE_BYTES);
            endcase
        end
        send_request(op, addr);
    endtask

    // Result side: a random stall per result, or the long hold-off once when
    // asked, counted here so the sender keeps pushing and in_ready drops.
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (hold_off)
            begin
                stall    = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Watchdog: ends the run once nothing has moved on either channel for too
    // long. The clearing pass after reset counts against it as well.
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        wait (rst_n === 1'b1);
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("refcounted_page_frame_allocator_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] lo_pick;
        logic [31:0] top_pick;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = rpfa_pkg::CFG_LOWEST;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = rpfa_pkg::MODE_ALLOC;
        page_address = '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_off     = 1'b0;
        window_lo    = '0;
        window_top   = rpfa_pkg::MEMORY_TOP_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed requests ----
        set_window(32'd0, rpfa_pkg::MEMORY_TOP_RESET);
        send_request(rpfa_pkg::MODE_ALLOC, 32'd0);              // empty stack
        send_request(rpfa_pkg::MODE_RELEASE, 32'd0);            // release at zero pushes
        send_request(rpfa_pkg::MODE_RELEASE, 32'd0);            // and pushes again
        send_request(rpfa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);      // address ignored
        send_request(rpfa_pkg::MODE_ALLOC, 32'd0);
        send_request(rpfa_pkg::MODE_ADDREF, 32'h03FF_F000);     // last frame in range
        send_request(rpfa_pkg::MODE_ADDREF, 32'h03FF_F000);
        send_request(rpfa_pkg::MODE_RELEASE, 32'h03FF_F000);    // still referenced
        send_request(rpfa_pkg::MODE_RELEASE, 32'h03FF_F000);    // reaches zero, pushed
        send_request(rpfa_pkg::MODE_RELEASE, 32'h0000_1001);    // misaligned
        send_request(rpfa_pkg::MODE_ADDREF, 32'(MAX_FRAMES * PAGE_BYTES)); // index too big
        send_request(rpfa_pkg::MODE_RELEASE, rpfa_pkg::MEMORY_TOP_RESET); // top of memory
        send_request(rpfa_pkg::MODE_ADDREF, 32'hFFFF_F000);
        send_request(rpfa_pkg::MODE_NONE, 32'hFFFF_FFFF);       // undefined mode
        send_request(rpfa_pkg::MODE_NONE, 32'd0);
        send_request(rpfa_pkg::MODE_ALLOC, 32'd0);
        set_window(32'h0001_0000, 32'h0002_0000);
        send_request(rpfa_pkg::MODE_RELEASE, 32'h0000_F000);    // below the window
        send_request(rpfa_pkg::MODE_RELEASE, 32'h0001_0000);    // lowest edge is allowed
        send_request(rpfa_pkg::MODE_ADDREF, 32'h0001_F000);     // last page under the top
        send_request(rpfa_pkg::MODE_ADDREF, 32'h0002_0000);     // top edge is rejected
        set_window(32'd0, 32'd0);                               // empty window
        send_request(rpfa_pkg::MODE_RELEASE, 32'd0);
        set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(rpfa_pkg::MODE_ADDREF, 32'hFFFF_F000);
        send_request(rpfa_pkg::MODE_ALLOC, 32'd0);              // allocate ignores window

        // ---- random phases, each under its own window ----
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    lo_pick  = '0;
                    top_pick = rpfa_pkg::MEMORY_TOP_RESET;
                end
                1:
                begin
                    lo_pick  = '0;
                    top_pick = '1;
                end
                2:
                begin
                    lo_pick  = 32'($urandom_range(0, 8) * PAGE_BYTES);
                    top_pick = lo_pick + 32'($urandom_range(8, 24) * PAGE_BYTES);
                end
                3:
                begin
                    // edges off the page grid
                    lo_pick  = 32'($urandom_range(1, 8) * PAGE_BYTES +
                                   $urandom_range(1, PAGE_BYTES - 1));
                    top_pick = lo_pick + 32'($urandom_range(8, 24) * PAGE_BYTES +
                                             $urandom_range(0, PAGE_BYTES - 1));
                end
                4:
                begin
                    lo_pick  = $urandom;
                    top_pick = $urandom;
                end
                default:
                begin
                    // straddles the end of the frame range
                    lo_pick  = 32'((MAX_FRAMES - 16) * PAGE_BYTES);
                    top_pick = 32'((MAX_FRAMES + 1) * PAGE_BYTES);
                end
            endcase
            set_window(lo_pick, top_pick);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (ph == 1)
            begin
                // back pressure run: sender flat out against a long hold-off
                tx_idle  = 1'b0;
                hold_off = 1'b1;
            end
            repeat (PHASE_ITEMS) random_request();
        end

        // ---- closing traffic under the reset window ----
        set_window(32'd0, rpfa_pkg::MEMORY_TOP_RESET);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (20) random_request();

        // ---- drain and verdict ----
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("refcounted_page_frame_allocator_top test passed");
        else
            $display("refcounted_page_frame_allocator_top test failed");
        $finish;
    end

endmodule
